// ===== rtl/core/aes128_pkg.sv =====
// shared types, s-box table and round functions for the aes-128 encryption block
package aes128_pkg;

   localparam int ROUNDS_DEFAULT = 10;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_payload_type;

   typedef enum logic [0:0] {
      CSR_KEY_LOW  = 1'b0,
      CSR_KEY_HIGH = 1'b1
   } csr_index_type;

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte k of the state sits at bits 8k+7:8k
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int col = 0; col < 4; col++) begin
         for (int row = 0; row < 4; row++) begin
            t[8*(row+4*col) +: 8] = SBOX_TABLE[s[8*(row+4*((col+row)%4)) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0  = s[32*c +: 8];
         a1  = s[32*c+8 +: 8];
         a2  = s[32*c+16 +: 8];
         a3  = s[32*c+24 +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
         t[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
         t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   // one round of the key schedule: previous round key to next
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
      logic [31:0]  t;
      logic [127:0] n;
      t[7:0]   = SBOX_TABLE[k[111:104]] ^ rcon;
      t[15:8]  = SBOX_TABLE[k[119:112]];
      t[23:16] = SBOX_TABLE[k[127:120]];
      t[31:24] = SBOX_TABLE[k[103:96]];
      n[31:0]   = k[31:0] ^ t;
      n[63:32]  = k[63:32] ^ n[31:0];
      n[95:64]  = k[95:64] ^ n[63:32];
      n[127:96] = k[127:96] ^ n[95:64];
      return n;
   endfunction

endpackage

// ===== rtl/core/aes128_block_encrypt.sv =====
// aes-128 encryption pipeline with fixed configured key and on-chip key expansion
//
// Encrypts one 128-bit block per clock while req_stall is low, under a key
// held in two 64-bit registers (index 0 = key bits 63:0, index 1 = key bits
// 127:64). Byte k of the plaintext and ciphertext is bits 8k+7:8k of {high,
// low}. The datapath is ROUNDS+1 register stages (initial key add, then one
// aes round per stage). rsp_valid is the valid bit of the last stage, and a
// new block may enter every cycle while req_stall is low. The round keys are
// computed by a sequential expander, one round key per cycle: after reset and
// after every key register write the block holds req_stall high while the
// schedule is rebuilt. Key writes are expected only when the pipeline is
// empty; a write to one half re-expands with the other half as it stands. A
// stall on the response side freezes the whole pipeline, nothing is dropped.
module aes128_block_encrypt #(
   parameter int ROUNDS = aes128_pkg::ROUNDS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // plaintext transactions
   input  logic                         req_valid,
   output logic                         req_stall,
   input  aes128_pkg::req_payload_type  req_payload,
   // ciphertext transactions
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output aes128_pkg::rsp_payload_type  rsp_payload,
   // key register writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  aes128_pkg::csr_index_type    csr_index,
   input  logic [63:0]                  csr_data
);

   localparam int CNT_W = $clog2(ROUNDS + 1);

   // key registers
   logic [63:0] key_low_ff, key_high_ff;

   // key expander
   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [127:0]     cur_key_ff;
   logic [7:0]       rcon_ff;
   logic [127:0]     next_key;
   logic             csr_write;

   // round key store, round r in lo/hi words r
   logic [63:0] rk_lo_ff [ROUNDS+1];
   logic [63:0] rk_hi_ff [ROUNDS+1];

   // datapath
   logic [127:0] state_ff [ROUNDS+1];
   logic         valid_ff [ROUNDS+1];
   logic         advance;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign next_key  = aes128_pkg::key_step(cur_key_ff, rcon_ff);

   // key registers and restart of the expansion on each write
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            aes128_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_data;
            aes128_pkg::CSR_KEY_HIGH: key_high_ff <= csr_data;
         endcase
      end
   end

   // sequential schedule: step 0 loads the cipher key, steps 1..ROUNDS derive one key each
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (csr_write) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(ROUNDS)) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !csr_write) begin
         if (cnt_ff == '0) begin
            cur_key_ff   <= {key_high_ff, key_low_ff};
            rcon_ff      <= 8'h01;
            rk_lo_ff[0]  <= key_low_ff;
            rk_hi_ff[0]  <= key_high_ff;
         end else begin
            cur_key_ff       <= next_key;
            rcon_ff          <= aes128_pkg::xtime(rcon_ff);
            rk_lo_ff[cnt_ff] <= next_key[63:0];
            rk_hi_ff[cnt_ff] <= next_key[127:64];
         end
      end
   end

   // whole pipeline moves together unless the last stage is held
   assign advance   = !valid_ff[ROUNDS] || !rsp_stall;
   assign req_stall = busy_ff || !advance;

   // stage 0: initial round key add
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff[0] <= {req_payload.block_high, req_payload.block_low}
                        ^ {rk_hi_ff[0], rk_lo_ff[0]};
      end
   end

   // stages 1..ROUNDS: one round each, the last without mix columns
   for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
      logic [127:0] sub_in;
      logic [127:0] state_in;

      always_comb begin
         sub_in = aes128_pkg::sub_shift(state_ff[r-1]);
         if (r == ROUNDS) begin
            state_in = sub_in ^ {rk_hi_ff[r], rk_lo_ff[r]};
         end else begin
            state_in = aes128_pkg::mix_columns(sub_in) ^ {rk_hi_ff[r], rk_lo_ff[r]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[r] <= 1'b0;
         end else if (advance) begin
            valid_ff[r] <= valid_ff[r-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            state_ff[r] <= state_in;
         end
      end
   end

   assign rsp_valid               = valid_ff[ROUNDS];
   assign rsp_payload.cipher_low  = state_ff[ROUNDS][63:0];
   assign rsp_payload.cipher_high = state_ff[ROUNDS][127:64];

   // no block may enter while the schedule is being rebuilt
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> req_stall)
      else $error("block accepted during key expansion");

   // a key write always restarts the expander
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (busy_ff && cnt_ff == '0))
      else $error("key write did not restart expansion");

   // expansion only ends after the final round key
   a_done_full: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> ($past(cnt_ff) == CNT_W'(ROUNDS)))
      else $error("key expansion ended early");

   // a held response stays valid while the pipeline is frozen
   a_hold_output: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ROUNDS] && rsp_stall) |=> valid_ff[ROUNDS])
      else $error("held response dropped");

endmodule
